[hw/rtl/dss_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dss_pkg
// Shared constants and types of the debounced square selector.
// ---------------------------------------------------------------------------
package dss_pkg;

  localparam int SLOTS      = 8;
  localparam int RUN_W      = 8;
  localparam int ID_W       = 8;
  localparam int CODE_W     = 7;
  localparam int POS_W      = 3;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int BOARD_W    = 64;

  localparam logic [CFG_IDX_W-1:0] REG_STABLE_CYCLES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_ROWS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPTION_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OPTION_SQUARES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OPTION_IDS     = 3'd4;

  localparam logic REQ_POLL  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef struct packed {
    logic             fire;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } lane_result_t;

endpackage
`default_nettype wire

[hw/rtl/dss_lane.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dss_lane
// One option slot: square decode and empty/occupied debouncer with rearm.
// ---------------------------------------------------------------------------
module dss_lane (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             clear,
  input  wire logic                             commit,
  input  wire logic [dss_pkg::CODE_W-1:0]       square,
  input  wire logic                             flip,
  input  wire logic [dss_pkg::BOARD_W-1:0]      occupancy,
  input  wire logic [dss_pkg::RUN_W-1:0]        need,
  output dss_pkg::lane_result_t                 res
);

  logic [dss_pkg::RUN_W-1:0] empty_run;
  logic [dss_pkg::RUN_W-1:0] occupied_run;
  logic                      armed;
  logic                      latched;

  logic [dss_pkg::RUN_W-1:0] empty_run_next;
  logic [dss_pkg::RUN_W-1:0] occupied_run_next;
  logic                      armed_next;
  logic                      latched_next;
  logic [dss_pkg::POS_W-1:0] row;
  logic [dss_pkg::POS_W-1:0] col;
  logic                      occ;
  logic                      fire;

  assign row = flip ? ~square[5:3] : square[5:3];
  assign col = square[2:0];
  assign occ = !square[6] && occupancy[{row, col}];

  always_comb begin
    empty_run_next    = empty_run;
    occupied_run_next = occupied_run;
    armed_next        = armed;
    latched_next      = latched;
    fire              = 1'b0;
    if (!occ) begin
      if (empty_run < need) begin
        empty_run_next = empty_run + 1'b1;
      end
      occupied_run_next = '0;
      latched_next      = 1'b0;
      if (empty_run_next >= need) begin
        armed_next = 1'b1;
      end
    end else begin
      empty_run_next = '0;
      if (!armed || latched) begin
        occupied_run_next = '0;
      end else begin
        if (occupied_run < need) begin
          occupied_run_next = occupied_run + 1'b1;
        end
        if (occupied_run_next >= need) begin
          armed_next   = 1'b0;
          latched_next = 1'b1;
          fire         = 1'b1;
        end
      end
    end
  end

  assign res.fire = fire;
  assign res.row  = row;
  assign res.col  = col;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      empty_run    <= '0;
      occupied_run <= '0;
      armed        <= 1'b0;
      latched      <= 1'b0;
    end else if (commit) begin
      empty_run    <= empty_run_next;
      occupied_run <= occupied_run_next;
      armed        <= armed_next;
      latched      <= latched_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/dss_merge.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dss_merge
// Priority merge of the slot lanes: first active lane that fires wins.
// ---------------------------------------------------------------------------
module dss_merge (
  input  wire dss_pkg::lane_result_t                  lane_res [dss_pkg::SLOTS],
  input  wire logic [dss_pkg::SLOTS-1:0]              active,
  input  wire logic [dss_pkg::SLOTS*dss_pkg::ID_W-1:0] ids,
  output logic      [dss_pkg::SLOTS-1:0]              commit,
  output logic                                        selected,
  output logic      [dss_pkg::ID_W-1:0]               option_id,
  output logic      [dss_pkg::POS_W-1:0]              square_row,
  output logic      [dss_pkg::POS_W-1:0]              square_col
);

  logic done;

  always_comb begin
    done       = 1'b0;
    commit     = '0;
    selected   = 1'b0;
    option_id  = '0;
    square_row = '0;
    square_col = '0;
    for (int i = 0; i < dss_pkg::SLOTS; i++) begin
      if (active[i] && !done) begin
        commit[i] = 1'b1;
        if (lane_res[i].fire) begin
          done       = 1'b1;
          selected   = 1'b1;
          option_id  = ids[i*dss_pkg::ID_W +: dss_pkg::ID_W];
          square_row = lane_res[i].row;
          square_col = lane_res[i].col;
        end
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/debounced_square_selector_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// debounced_square_selector_core
// Eight debounced option slots watching squares of a 64-bit occupancy scan.
//
// Input channel (item_valid/item_stall): one transaction carries req_type and
// a 64-bit occupancy scan. Poll steps the active slot debouncers up to the
// first that fires; clear resets every debouncer and reports no selection.
// Output channel (result_valid/result_stall): one transaction per input,
// with selected, option_id, square_row and square_col.
// result_valid rises in the cycle after input acceptance. Throughput is
// one transaction per cycle unless stalled: the eight slot lanes evaluate
// in parallel and the merge picks the first firing slot in the same cycle.
// Configuration is written through cfg_we/cfg_index/cfg_data, only while
// idle, by the user; the block does not enforce this. Reset clears all
// debouncers, sets stable_cycles to 1 and the other registers to 0, and
// empties the result register. While the receiver stalls, the result
// register holds and item_stall is raised so no further input is accepted.
// ---------------------------------------------------------------------------
module debounced_square_selector_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [dss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dss_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire logic                              req_type,
  input  wire logic [dss_pkg::BOARD_W-1:0]       occupancy,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output logic                                   selected,
  output logic      [dss_pkg::ID_W-1:0]          option_id,
  output logic      [dss_pkg::POS_W-1:0]         square_row,
  output logic      [dss_pkg::POS_W-1:0]         square_col
);

  logic [dss_pkg::RUN_W-1:0]                 stable_cycles;
  logic                                      flip_rows;
  logic [dss_pkg::COUNT_W-1:0]               option_count;
  logic [dss_pkg::SLOTS*dss_pkg::CODE_W-1:0] option_squares;
  logic [dss_pkg::SLOTS*dss_pkg::ID_W-1:0]   option_ids;

  logic                        item_acc;
  logic                        poll;
  logic                        clear;
  logic [dss_pkg::RUN_W-1:0]   need;
  logic [dss_pkg::COUNT_W-1:0] count;
  logic [dss_pkg::SLOTS-1:0]   active;
  logic [dss_pkg::SLOTS-1:0]   commit;
  dss_pkg::lane_result_t       lane_res [dss_pkg::SLOTS];
  logic                        m_selected;
  logic [dss_pkg::ID_W-1:0]    m_option_id;
  logic [dss_pkg::POS_W-1:0]   m_row;
  logic [dss_pkg::POS_W-1:0]   m_col;
  logic [dss_pkg::SLOTS-1:0]   fire_vec;

  assign item_stall = result_valid && result_stall;
  assign item_acc   = item_valid && !item_stall;
  assign clear      = item_acc && (req_type == dss_pkg::REQ_CLEAR);
  assign poll       = item_acc && (req_type == dss_pkg::REQ_POLL);

  assign need  = (stable_cycles == '0) ? dss_pkg::RUN_W'(1) : stable_cycles;
  assign count = (option_count > dss_pkg::COUNT_W'(dss_pkg::SLOTS)) ?
                 dss_pkg::COUNT_W'(dss_pkg::SLOTS) : option_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_cycles  <= dss_pkg::RUN_W'(1);
      flip_rows      <= 1'b0;
      option_count   <= '0;
      option_squares <= '0;
      option_ids     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dss_pkg::REG_STABLE_CYCLES:  stable_cycles  <= cfg_data[dss_pkg::RUN_W-1:0];
        dss_pkg::REG_FLIP_ROWS:      flip_rows      <= cfg_data[0];
        dss_pkg::REG_OPTION_COUNT:   option_count   <= cfg_data[dss_pkg::COUNT_W-1:0];
        dss_pkg::REG_OPTION_SQUARES:
          option_squares <= cfg_data[dss_pkg::SLOTS*dss_pkg::CODE_W-1:0];
        dss_pkg::REG_OPTION_IDS:     option_ids     <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < dss_pkg::SLOTS; i++) begin : g_lane
    assign active[i]   = dss_pkg::COUNT_W'(i) < count;
    assign fire_vec[i] = lane_res[i].fire;

    dss_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .clear     (clear),
      .commit    (poll && commit[i]),
      .square    (option_squares[i*dss_pkg::CODE_W +: dss_pkg::CODE_W]),
      .flip      (flip_rows),
      .occupancy (occupancy),
      .need      (need),
      .res       (lane_res[i])
    );
  end

  dss_merge u_merge (
    .lane_res   (lane_res),
    .active     (active),
    .ids        (option_ids),
    .commit     (commit),
    .selected   (m_selected),
    .option_id  (m_option_id),
    .square_row (m_row),
    .square_col (m_col)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_acc) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      if (clear) begin
        selected   <= 1'b0;
        option_id  <= '0;
        square_row <= '0;
        square_col <= '0;
      end else begin
        selected   <= m_selected;
        option_id  <= m_option_id;
        square_row <= m_row;
        square_col <= m_col;
      end
    end
  end

  a_clear_no_select: assert property (@(posedge clk) disable iff (rst)
    clear |=> result_valid && !selected)
    else $error("clear request produced a selection");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !selected |->
      option_id == '0 && square_row == '0 && square_col == '0)
    else $error("non-selected result carries nonzero fields");

  a_single_winner: assert property (@(posedge clk) disable iff (rst)
    $onehot0(fire_vec & commit))
    else $error("more than one committed lane fired");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    item_acc |=> result_valid)
    else $error("accepted transaction produced no result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(selected))
    else $error("stalled result changed");

endmodule
`default_nettype wire
